### sv/spo2at_pkg.sv
// ----------------------------------------------------------------------------
// spo2at_pkg
// Shared types and constants of the SpO2 alarm tone controller: mode codes,
// register indexes, reset values, melody table and the state bundles.
// ----------------------------------------------------------------------------
package spo2at_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_ALARM   = 2'd1,
      MODE_PERSIST = 2'd2,
      MODE_ERROR   = 2'd3
   } mode_type;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RAW_LOW_LIMIT       = 4'd0,
      CSR_RAW_HIGH_LIMIT      = 4'd1,
      CSR_ALARM_RAW_THRESHOLD = 4'd2,
      CSR_PERSIST_TIME_MS     = 4'd3,
      CSR_ERROR_INTERVAL_MS   = 4'd4,
      CSR_PERSIST_TONE_HZ     = 4'd5,
      CSR_ERROR_TONE_HZ       = 4'd6,
      CSR_MELODY_TONE_HZ      = 4'd7
   } csr_index_type;

   localparam logic [11:0] RAW_LOW_LIMIT_RST       = 12'd50;
   localparam logic [11:0] RAW_HIGH_LIMIT_RST      = 12'd4000;
   localparam logic [11:0] ALARM_RAW_THRESHOLD_RST = 12'd2730;
   localparam logic [15:0] PERSIST_TIME_MS_RST     = 16'd30000;
   localparam logic [9:0]  ERROR_INTERVAL_MS_RST   = 10'd300;
   localparam logic [15:0] PERSIST_TONE_HZ_RST     = 16'd2000;
   localparam logic [15:0] ERROR_TONE_HZ_RST       = 16'd600;
   localparam logic [15:0] MELODY_TONE_HZ_RST      = 16'd1319;

   localparam logic [9:0]  SATURATION_RST = 10'd980;
   localparam logic [9:0]  SATURATION_BASE = 10'd700;
   localparam logic [8:0]  SATURATION_SPAN = 9'd300;
   localparam logic [12:0] RAW_FULL_SCALE  = 13'd4095;

   localparam logic [3:0] MELODY_LAST = 4'd9;
   localparam logic [6:0] TONE_TICKS  = 7'd125;

   typedef struct packed {
      logic [11:0] raw_low_limit;
      logic [11:0] raw_high_limit;
      logic [11:0] alarm_raw_threshold;
      logic [15:0] persist_time_ms;
      logic [9:0]  error_interval_ms;
      logic [15:0] persist_tone_hz;
      logic [15:0] error_tone_hz;
      logic [15:0] melody_tone_hz;
   } config_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] alarm_elapsed;
      logic [3:0]  note_index;
      logic [8:0]  note_elapsed;
      logic [6:0]  note_remaining;
      logic [9:0]  error_elapsed;
      logic        beep_phase;
      logic [9:0]  saturation_value;
   } state_type;

   typedef struct packed {
      mode_type    alarm_mode;
      logic        tone_on;
      logic [15:0] tone_hz;
      logic [9:0]  spo2_tenths;
   } result_type;

   // wait before a melody step starts, the long rest closes the phrase
   function automatic logic [8:0] step_wait(input logic [3:0] idx);
      logic [8:0] w;
      w = (idx == MELODY_LAST) ? 9'd325 : 9'd163;
      return w;
   endfunction

   function automatic logic step_sounds(input logic [3:0] idx);
      logic s;
      case (idx)
         4'd0, 4'd1, 4'd3, 4'd4, 4'd6, 4'd7: s = 1'b1;
         default: s = 1'b0;
      endcase
      return s;
   endfunction

endpackage

### sv/spo2at_tick_logic.sv
// ----------------------------------------------------------------------------
// spo2at_tick_logic
// Next state and result for one millisecond tick: timers, sample handling,
// persistence timeout, melody sequencer and error beep.
// ----------------------------------------------------------------------------
module spo2at_tick_logic (
   input  spo2at_pkg::config_type cfg,
   input  spo2at_pkg::state_type  cur,
   input  logic                   sample_present,
   input  logic [11:0]            raw_sample,
   output spo2at_pkg::state_type  nxt,
   output spo2at_pkg::result_type res
);
   import spo2at_pkg::*;

   logic [15:0] alarm_el_inc;
   logic [8:0]  note_el_inc;
   logic [9:0]  error_el_inc;
   logic        raw_bad;
   logic [20:0] prod;
   logic [8:0]  quot_est;
   logic [12:0] rem_est;
   logic [8:0]  quot;
   mode_type    mode_base;
   mode_type    mode_smp;
   mode_type    mode_fin;
   logic        changed;
   logic [15:0] alarm_el;
   logic [6:0]  note_rem;
   logic        beep;
   logic [3:0]  idx;
   logic [8:0]  note_el;
   logic [3:0]  note_idx;
   logic [9:0]  error_el;
   logic        tone_on;
   logic [15:0] tone_hz;

   // raw*300/4095: estimate by /4096, remainder stays below twice the divisor
   assign prod     = 21'(raw_sample) * 21'(SATURATION_SPAN);
   assign quot_est = prod[20:12];
   assign rem_est  = {1'b0, prod[11:0]} + {4'b0, quot_est};
   assign quot     = quot_est + ((rem_est >= RAW_FULL_SCALE) ? 9'd1 : 9'd0);

   assign alarm_el_inc = (cur.alarm_elapsed == '1) ? cur.alarm_elapsed
                                                    : cur.alarm_elapsed + 16'd1;
   assign note_el_inc  = (cur.note_elapsed == '1) ? cur.note_elapsed
                                                   : cur.note_elapsed + 9'd1;
   assign error_el_inc = (cur.error_elapsed == '1) ? cur.error_elapsed
                                                    : cur.error_elapsed + 10'd1;

   assign raw_bad = (raw_sample < cfg.raw_low_limit) || (raw_sample > cfg.raw_high_limit);

   always_comb begin
      mode_base = (cur.mode == MODE_ERROR) ? MODE_NORMAL : cur.mode;
      mode_smp  = cur.mode;
      if (sample_present) begin
         if (raw_bad) begin
            mode_smp = MODE_ERROR;
         end else if (raw_sample < cfg.alarm_raw_threshold) begin
            mode_smp = (mode_base == MODE_NORMAL) ? MODE_ALARM : mode_base;
         end else begin
            mode_smp = MODE_NORMAL;
         end
      end

      // entering alarm restarts the persistence timer
      alarm_el = (mode_smp == MODE_ALARM && cur.mode != MODE_ALARM) ? 16'd0 : alarm_el_inc;

      mode_fin = mode_smp;
      if (mode_smp == MODE_ALARM && alarm_el >= cfg.persist_time_ms) begin
         mode_fin = MODE_PERSIST;
      end

      changed  = (mode_smp != cur.mode) || (mode_fin != mode_smp);
      note_rem = changed ? 7'd0 : cur.note_remaining;
      beep     = changed ? 1'b0 : cur.beep_phase;

      idx      = (cur.note_index > MELODY_LAST) ? 4'd0 : cur.note_index;
      note_el  = note_el_inc;
      note_idx = cur.note_index;
      error_el = error_el_inc;
      tone_on  = 1'b0;
      tone_hz  = 16'd0;

      case (mode_fin)
         MODE_ALARM: begin
            if (note_el_inc >= step_wait(idx)) begin
               note_el  = 9'd0;
               note_rem = step_sounds(idx) ? TONE_TICKS : 7'd0;
               note_idx = (idx == MELODY_LAST) ? 4'd0 : idx + 4'd1;
            end
            if (note_rem != 7'd0) begin
               tone_on = 1'b1;
               tone_hz = cfg.melody_tone_hz;
            end
         end
         MODE_PERSIST: begin
            tone_on = 1'b1;
            tone_hz = cfg.persist_tone_hz;
         end
         MODE_ERROR: begin
            if (error_el_inc >= cfg.error_interval_ms) begin
               error_el = 10'd0;
               beep     = ~beep;
            end
            if (beep) begin
               tone_on = 1'b1;
               tone_hz = cfg.error_tone_hz;
            end
         end
         default: begin
         end
      endcase

      nxt.mode             = mode_fin;
      nxt.alarm_elapsed    = alarm_el;
      nxt.note_index       = note_idx;
      nxt.note_elapsed     = note_el;
      nxt.note_remaining   = (note_rem != 7'd0) ? note_rem - 7'd1 : 7'd0;
      nxt.error_elapsed    = error_el;
      nxt.beep_phase       = beep;
      nxt.saturation_value = (sample_present && !raw_bad) ? SATURATION_BASE + 10'(quot)
                                                          : cur.saturation_value;

      res.alarm_mode  = mode_fin;
      res.tone_on     = tone_on;
      res.tone_hz     = tone_hz;
      res.spo2_tenths = nxt.saturation_value;
   end

endmodule

### sv/spo2_alarm_tone_controller_core.sv
// ----------------------------------------------------------------------------
// spo2_alarm_tone_controller_core
// SpO2 alarm tone controller, one patient channel, with register port.
// ----------------------------------------------------------------------------
// Each request is one millisecond tick, optionally carrying a raw oximeter
// sample, and gives exactly one response (mode, buzzer on/off, buzzer
// frequency, last saturation in tenths). A request is taken every clock
// cycle while req_stall is low; its response is registered and appears
// on the cycle after acceptance. The state update loop (mode, timers,
// melody position) is combinational and is registered per accepted tick.
// The response register holds a result while rsp_stall is high, and
// req_stall is raised only when that register is full and stalled.
// Register writes are always accepted and should be made while idle.
module spo2_alarm_tone_controller_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_sample_present,
   input  logic [11:0]                       req_raw_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_alarm_mode,
   output logic                              rsp_tone_on,
   output logic [15:0]                       rsp_tone_hz,
   output logic [9:0]                        rsp_spo2_tenths,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [spo2at_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [spo2at_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import spo2at_pkg::*;

   config_type cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type res_in;
   result_type res_ff;
   logic       rsp_valid_ff;
   logic       req_take;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   spo2at_tick_logic u_tick (
      .cfg            (cfg_ff),
      .cur            (state_ff),
      .sample_present (req_sample_present),
      .raw_sample     (req_raw_sample),
      .nxt            (state_in),
      .res            (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raw_low_limit       <= RAW_LOW_LIMIT_RST;
         cfg_ff.raw_high_limit      <= RAW_HIGH_LIMIT_RST;
         cfg_ff.alarm_raw_threshold <= ALARM_RAW_THRESHOLD_RST;
         cfg_ff.persist_time_ms     <= PERSIST_TIME_MS_RST;
         cfg_ff.error_interval_ms   <= ERROR_INTERVAL_MS_RST;
         cfg_ff.persist_tone_hz     <= PERSIST_TONE_HZ_RST;
         cfg_ff.error_tone_hz       <= ERROR_TONE_HZ_RST;
         cfg_ff.melody_tone_hz      <= MELODY_TONE_HZ_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RAW_LOW_LIMIT:       cfg_ff.raw_low_limit       <= csr_wdata[11:0];
            CSR_RAW_HIGH_LIMIT:      cfg_ff.raw_high_limit      <= csr_wdata[11:0];
            CSR_ALARM_RAW_THRESHOLD: cfg_ff.alarm_raw_threshold <= csr_wdata[11:0];
            CSR_PERSIST_TIME_MS:     cfg_ff.persist_time_ms     <= csr_wdata;
            CSR_ERROR_INTERVAL_MS:   cfg_ff.error_interval_ms   <= csr_wdata[9:0];
            CSR_PERSIST_TONE_HZ:     cfg_ff.persist_tone_hz     <= csr_wdata;
            CSR_ERROR_TONE_HZ:       cfg_ff.error_tone_hz       <= csr_wdata;
            CSR_MELODY_TONE_HZ:      cfg_ff.melody_tone_hz      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode             <= MODE_NORMAL;
         state_ff.alarm_elapsed    <= '0;
         state_ff.note_index       <= '0;
         state_ff.note_elapsed     <= '0;
         state_ff.note_remaining   <= '0;
         state_ff.error_elapsed    <= '0;
         state_ff.beep_phase       <= 1'b0;
         state_ff.saturation_value <= SATURATION_RST;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alarm_mode  = res_ff.alarm_mode;
   assign rsp_tone_on     = res_ff.tone_on;
   assign rsp_tone_hz     = res_ff.tone_hz;
   assign rsp_spo2_tenths = res_ff.spo2_tenths;

endmodule
